// ----- rtl/olme_pkg.sv -----
`timescale 1ns / 1ps
package olme_pkg;
	localparam int CAPACITY = 256;
	localparam int BOARD_CELLS = 9;
	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int KEY_BITS = 4 * BOARD_CELLS;

	localparam logic [2:0] FN_ADD_FIRST = 3'd0;
	localparam logic [2:0] FN_ADD_LAST = 3'd1;
	localparam logic [2:0] FN_POP_FIRST = 3'd2;
	localparam logic [2:0] FN_POP_LAST = 3'd3;
	localparam logic [2:0] FN_POP_BEST = 3'd4;
	localparam logic [2:0] FN_FIND = 3'd5;
	localparam logic [2:0] FN_REMOVE = 3'd6;
	localparam logic [2:0] FN_CLEAR = 3'd7;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_EMPTY = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_BAD_SLOT = 3'd4;

	typedef struct packed {
		logic [2:0] func;
		logic [23:0] score;
		logic [35:0] board_key;
		logic [15:0] item_tag;
		logic [7:0] slot_sel;
	} in_word_t;

	typedef struct packed {
		logic [2:0] status;
		logic [23:0] out_score;
		logic [35:0] out_board;
		logic [15:0] out_tag;
		logic [7:0] out_slot;
		logic [8:0] entry_count;
	} out_word_t;

	// one entry as stored in memory
	typedef struct packed {
		logic [23:0] score;
		logic [35:0] board;
		logic [15:0] tag;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// controller to datapath
	typedef struct packed {
		logic load_req;     // capture input word
		logic alloc_step;   // test one slot for allocation
		logic alloc_rst;    // restart allocation search at 0
		logic rd_entry;     // sel to best slot for pop_best
		logic walk_adv;     // move walk pointer to fetched next
		logic walk_head;    // walk pointer to head
		logic walk_sel;     // walk pointer to selected slot
		logic best_init;    // take fetched entry as best
		logic best_cmp;     // compare fetched entry with best
		logic do_add;       // write new entry and link it
		logic link_prev;    // write prev of head for add_first
		logic link_next;    // write next of tail for add_last
		logic rd_prev;      // read prev link of selected slot
		logic unlink;       // unlink selected slot
		logic fix_next;     // next[p] = n
		logic fix_prev;     // prev[n] = p
		logic clear;
		logic [2:0] status;
		logic report;       // output carries entry fields
		logic slot_only;    // output carries slot only
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] func;
		logic empty;
		logic full;
		logic one_left;
		logic alloc_hit;    // tested slot is free
		logic alloc_end;    // tested last slot
		logic sel_in_use;
		logic sel_range;
		logic sel_head;
		logic sel_tail;
		logic walk_last;    // walk index reached count-1
		logic key_hit;
	} sts_t;
endpackage

// ----- rtl/olme_ram.sv -----
`timescale 1ns / 1ps
module olme_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/olme_datapath.sv -----
`timescale 1ns / 1ps
module olme_datapath (
	input logic clk,
	input logic arst_n,
	input olme_pkg::in_word_t in_word,
	input olme_pkg::cmd_t cmd,
	output olme_pkg::sts_t sts,
	output olme_pkg::out_word_t out_word
);
	import olme_pkg::*;

	in_word_t req_q;
	logic [CAPACITY-1:0] in_use_q;
	logic [SLOT_W-1:0] head_q, tail_q, walk_q, sel_q, best_q, alloc_q, pnb_q;
	logic [CNT_W-1:0] count_q, idx_q;
	logic [23:0] best_score_q;
	entry_t ent_rd, best_ent_q;
	logic [SLOT_W-1:0] next_rd, prev_rd;
	out_word_t out_q;

	logic ent_we, next_we, prev_we;
	logic [SLOT_W-1:0] ent_wa, next_wa, prev_wa, next_wd, prev_wd, rd_addr;
	logic [SLOT_W-1:0] new_slot, next_ra, prev_ra;
	entry_t ent_wd;

	assign new_slot = alloc_q;
	assign ent_we = cmd.do_add;
	assign ent_wa = new_slot;
	assign ent_wd = '{score: req_q.score, board: req_q.board_key, tag: req_q.item_tag};
	assign rd_addr = walk_q;
	assign next_ra = walk_q;
	assign prev_ra = sel_q;

	// link writes
	always_comb begin
		next_we = 1'b0;
		next_wa = new_slot;
		next_wd = new_slot;
		prev_we = 1'b0;
		prev_wa = new_slot;
		prev_wd = new_slot;
		if (cmd.do_add) begin
			next_we = 1'b1;
			prev_we = 1'b1;
			if (count_q != '0 && req_q.func == FN_ADD_FIRST) begin
				next_wd = head_q;
			end else if (count_q != '0) begin
				prev_wd = tail_q;
			end
		end else if (cmd.link_prev) begin
			prev_we = 1'b1;
			prev_wa = head_q;
			prev_wd = new_slot;
		end else if (cmd.link_next) begin
			next_we = 1'b1;
			next_wa = tail_q;
			next_wd = new_slot;
		end else if (cmd.fix_next) begin
			next_we = 1'b1;
			next_wa = pnb_q;
			next_wd = walk_q;
		end else if (cmd.fix_prev) begin
			prev_we = 1'b1;
			prev_wa = walk_q;
			prev_wd = pnb_q;
		end
	end

	olme_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_entry (
		.clk(clk), .we(ent_we), .waddr(ent_wa), .wdata(ent_wd),
		.raddr(rd_addr), .rdata(ent_rd)
	);
	olme_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_next (
		.clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
		.raddr(next_ra), .rdata(next_rd)
	);
	olme_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_prev (
		.clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
		.raddr(prev_ra), .rdata(prev_rd)
	);

	logic [KEY_BITS-1:0] key_a, key_b;
	assign key_a = ent_rd.board[KEY_BITS-1:0];
	assign key_b = req_q.board_key[KEY_BITS-1:0];

	assign sts.func = req_q.func;
	assign sts.empty = (count_q == '0);
	assign sts.full = (count_q == CNT_W'(CAPACITY));
	assign sts.one_left = (count_q == CNT_W'(1));
	assign sts.alloc_hit = !in_use_q[alloc_q];
	assign sts.alloc_end = (alloc_q == SLOT_W'(CAPACITY - 1));
	assign sts.sel_range = ({1'b0, req_q.slot_sel} < 9'(CAPACITY));
	assign sts.sel_in_use = in_use_q[req_q.slot_sel[SLOT_W-1:0]];
	assign sts.sel_head = (sel_q == head_q);
	assign sts.sel_tail = (sel_q == tail_q);
	assign sts.walk_last = (idx_q + CNT_W'(1) >= count_q);
	assign sts.key_hit = (key_a == key_b);

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= in_word;
		end
		if (cmd.best_init) begin
			best_ent_q <= ent_rd;
			best_score_q <= ent_rd.score;
			best_q <= walk_q;
		end else if (cmd.best_cmp && ent_rd.score < best_score_q) begin
			best_ent_q <= ent_rd;
			best_score_q <= ent_rd.score;
			best_q <= walk_q;
		end
		if (cmd.rd_prev) begin
			pnb_q <= prev_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			walk_q <= '0;
			sel_q <= '0;
			idx_q <= '0;
			alloc_q <= '0;
			out_q <= '0;
		end else begin
			if (cmd.alloc_rst) begin
				alloc_q <= '0;
			end else if (cmd.alloc_step && !sts.alloc_hit) begin
				alloc_q <= alloc_q + SLOT_W'(1);
			end
			if (cmd.walk_head) begin
				walk_q <= head_q;
				idx_q <= '0;
			end else if (cmd.walk_adv) begin
				walk_q <= next_rd;
				idx_q <= idx_q + CNT_W'(1);
			end else if (cmd.walk_sel) begin
				walk_q <= (req_q.func == FN_POP_BEST) ? best_q : sel_q;
			end
			// pick the slot to remove
			if (cmd.load_req) begin
				unique case (in_word.func)
					FN_POP_LAST: sel_q <= tail_q;
					FN_REMOVE: sel_q <= in_word.slot_sel[SLOT_W-1:0];
					default: sel_q <= head_q;
				endcase
			end else if (cmd.rd_entry && req_q.func == FN_POP_BEST) begin
				sel_q <= best_q;
			end
			if (cmd.do_add) begin
				in_use_q[new_slot] <= 1'b1;
				count_q <= count_q + CNT_W'(1);
				if (count_q == '0) begin
					head_q <= new_slot;
					tail_q <= new_slot;
				end
			end
			// move head or tail once the old end has been linked
			if (cmd.link_prev) begin
				head_q <= new_slot;
			end
			if (cmd.link_next) begin
				tail_q <= new_slot;
			end
			if (cmd.unlink) begin
				in_use_q[sel_q] <= 1'b0;
				count_q <= count_q - CNT_W'(1);
				if (count_q <= CNT_W'(1)) begin
					head_q <= '0;
					tail_q <= '0;
				end else if (sel_q == head_q) begin
					head_q <= next_rd;
				end else if (sel_q == tail_q) begin
					tail_q <= prev_rd;
				end
			end
			if (cmd.clear) begin
				in_use_q <= '0;
				head_q <= '0;
				tail_q <= '0;
				count_q <= '0;
			end
			if (cmd.out_load) begin
				out_q.status <= cmd.status;
				out_q.out_score <= cmd.report ? best_ent_q.score : '0;
				out_q.out_board <= cmd.report ? best_ent_q.board : '0;
				out_q.out_tag <= cmd.report ? best_ent_q.tag : '0;
				out_q.out_slot <= cmd.report ? 8'(best_q) :
					(cmd.slot_only ? 8'(new_slot) : '0);
				out_q.entry_count <= 9'(count_q);
			end
		end
	end

	assign out_word = out_q;
endmodule

// ----- rtl/olme_ctrl.sv -----
`timescale 1ns / 1ps
module olme_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	input olme_pkg::sts_t sts,
	output olme_pkg::cmd_t cmd
);
	import olme_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISPATCH = 4'd1;
	localparam logic [3:0] S_ALLOC = 4'd2;
	localparam logic [3:0] S_ADD = 4'd3;
	localparam logic [3:0] S_LINK = 4'd4;
	localparam logic [3:0] S_RD = 4'd5;     // memory read in flight
	localparam logic [3:0] S_EVAL = 4'd6;   // fetched entry valid
	localparam logic [3:0] S_RDSEL = 4'd7;  // read selected slot
	localparam logic [3:0] S_GETSEL = 4'd8; // entry, next, prev valid
	localparam logic [3:0] S_FIXN = 4'd9;
	localparam logic [3:0] S_FIXP = 4'd10;
	localparam logic [3:0] S_FIXW = 4'd11;
	localparam logic [3:0] S_RESP = 4'd12;
	localparam logic [3:0] S_OUT = 4'd13;

	logic [3:0] state_q, state_d;
	logic [2:0] status_q, status_d;
	logic report_q, report_d, slot_q, slot_d, mid_q, mid_d;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		status_d = status_q;
		report_d = report_q;
		slot_d = slot_q;
		mid_d = mid_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				status_d = ST_OK;
				report_d = 1'b0;
				slot_d = 1'b0;
				unique case (sts.func)
					FN_ADD_FIRST, FN_ADD_LAST: begin
						cmd.alloc_rst = 1'b1;
						if (sts.full) begin
							status_d = ST_FULL;
							state_d = S_RESP;
						end else begin
							state_d = S_ALLOC;
						end
					end
					FN_POP_FIRST, FN_POP_LAST: begin
						if (sts.empty) begin
							status_d = ST_EMPTY;
							state_d = S_RESP;
						end else begin
							state_d = S_RDSEL;
						end
					end
					FN_POP_BEST: begin
						cmd.walk_head = 1'b1;
						if (sts.empty) begin
							status_d = ST_EMPTY;
							state_d = S_RESP;
						end else begin
							state_d = S_RD;
						end
					end
					FN_FIND: begin
						cmd.walk_head = 1'b1;
						status_d = ST_NOT_FOUND;
						state_d = sts.empty ? S_RESP : S_RD;
					end
					FN_REMOVE: begin
						if (!sts.sel_range || !sts.sel_in_use) begin
							status_d = ST_BAD_SLOT;
							state_d = S_RESP;
						end else begin
							state_d = S_RDSEL;
						end
					end
					default: begin
						cmd.clear = 1'b1;
						state_d = S_RESP;
					end
				endcase
			end
			S_ALLOC: begin
				cmd.alloc_step = 1'b1;
				if (sts.alloc_hit) begin
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				cmd.do_add = 1'b1;
				slot_d = 1'b1;
				state_d = (sts.empty) ? S_RESP : S_LINK;
			end
			S_LINK: begin
				// head or tail still holds the old end; point it at the new slot
				cmd.link_prev = (sts.func == FN_ADD_FIRST);
				cmd.link_next = (sts.func != FN_ADD_FIRST);
				state_d = S_RESP;
			end
			S_RD: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (sts.func == FN_FIND) begin
					if (sts.key_hit) begin
						cmd.best_init = 1'b1;
						status_d = ST_OK;
						report_d = 1'b1;
						state_d = S_RESP;
					end else if (sts.walk_last) begin
						state_d = S_RESP;
					end else begin
						cmd.walk_adv = 1'b1;
						state_d = S_RD;
					end
				end else begin
					cmd.best_init = mid_q ? 1'b0 : 1'b1;
					cmd.best_cmp = mid_q;
					if (sts.walk_last) begin
						mid_d = 1'b0;
						state_d = S_RDSEL;
					end else begin
						mid_d = 1'b1;
						cmd.walk_adv = 1'b1;
						state_d = S_RD;
					end
				end
			end
			S_RDSEL: begin
				// sel settles to best on this cycle for pop_best; walk follows
				cmd.rd_entry = 1'b1;
				cmd.walk_sel = 1'b1;
				state_d = S_FIXW;
			end
			S_FIXW: begin
				state_d = S_GETSEL;
			end
			S_GETSEL: begin
				cmd.best_init = 1'b1;
				cmd.rd_prev = 1'b1;
				cmd.unlink = 1'b1;
				report_d = 1'b1;
				if (!sts.one_left && !sts.sel_head && !sts.sel_tail) begin
					// advance walk to the next entry of sel
					cmd.walk_adv = 1'b1;
					state_d = S_FIXN;
				end else begin
					state_d = S_RESP;
				end
			end
			S_FIXN: begin
				// walk holds n (next of sel), pnb holds p
				cmd.fix_next = 1'b1;
				state_d = S_FIXP;
			end
			S_FIXP: begin
				cmd.fix_prev = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				cmd.out_load = 1'b1;
				cmd.status = status_q;
				cmd.report = report_q;
				cmd.slot_only = slot_q;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			status_q <= ST_OK;
			report_q <= 1'b0;
			slot_q <= 1'b0;
			mid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			status_q <= status_d;
			report_q <= report_d;
			slot_q <= slot_d;
			mid_q <= mid_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_add |-> !sts.full) else $error("add into full store");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.unlink |-> !sts.empty) else $error("unlink on empty list");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.alloc_step && sts.alloc_end) |-> sts.alloc_hit)
		else $error("free slot search ran past the last slot");
endmodule

// ----- rtl/ordered_list_with_min_extract_unit.sv -----
`timescale 1ns / 1ps
// Bounded open list of up to CAPACITY entries (score, board key, tag) kept in
// linked order. One request at a time, from the accepted word to the result
// word. An add first searches upward from slot 0 for the lowest free slot,
// then writes the entry and, in a non-empty list, links the old head or tail.
// Head/tail pops and removes read the selected slot and unlink it; an entry in
// the middle of the list also needs its neighbours' links fixed. Lowest-score
// pop and find walk the list from the head (one registered read of the entry
// and link memories per step). Clear, an add to a full list, a pop of an empty
// list and a bad slot go straight to the result. No clearing pass is needed
// after reset. The result word is held until taken; the next word can be
// accepted in the cycle after that.
module ordered_list_with_min_extract_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input olme_pkg::in_word_t in_word,
	output logic out_valid,
	input logic out_stall,
	output olme_pkg::out_word_t out_word
);
	import olme_pkg::*;

	cmd_t cmd;
	sts_t sts;

	olme_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	olme_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_word(in_word), .cmd(cmd), .sts(sts),
		.out_word(out_word)
	);
endmodule
